[hdl/nearest_scaler_letterbox_swizzle_macros.svh]
// ----------------------------------------------------------------------------
// nearest scaler assertion macros
// shared concurrent assertion wrappers clocked on aclk
// ----------------------------------------------------------------------------
`ifndef NEAREST_SCALER_LETTERBOX_SWIZZLE_MACROS_SVH
`define NEAREST_SCALER_LETTERBOX_SWIZZLE_MACROS_SVH

// same-cycle implication
`define NSLS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NSLS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/nsls_pkg.sv]
// ----------------------------------------------------------------------------
// nsls_pkg
// constants and types of the nearest-neighbor letterbox scaler
// ----------------------------------------------------------------------------
package nsls_pkg;

    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int MAX_DST_DIM    = 4096;

    localparam int SW_W   = 9;
    localparam int DW_W   = 13;
    localparam int CX_W   = 12;
    localparam int PIX_W  = 32;
    localparam int XA_W   = $clog2(MAX_SRC_WIDTH);
    localparam int YA_W   = $clog2(MAX_SRC_HEIGHT);
    localparam int ADDR_W = XA_W + YA_W;
    localparam int FRAME_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int NUM_W  = CX_W + SW_W;
    localparam int Q_W    = SW_W;
    localparam int PROD_W = SW_W + DW_W;
    localparam int SUC_W  = $clog2(DW_W);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = DW_W;

    localparam logic [PIX_W-1:0] BORDER_PIXEL = 32'hFF00_0000;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_SWAP_RB    = 3'd4,
        REG_KEEP_ASP   = 3'd5
    } cfg_reg_t;

    // one pipeline stage of the datapath
    typedef struct packed {
        logic              valid;
        logic              rd;
        logic              wr_ok;
        logic              err;
        logic              border;
        logic [CX_W-1:0]   ax;
        logic [CX_W-1:0]   ay;
        logic [PIX_W-1:0]  pix;
        logic [NUM_W-1:0]  rem_x;
        logic [NUM_W-1:0]  rem_y;
        logic [Q_W-1:0]    q_x;
        logic [Q_W-1:0]    q_y;
    } stage_t;

endpackage

[hdl/nearest_scaler_letterbox_swizzle.sv]
// ----------------------------------------------------------------------------
// nearest_scaler_letterbox_swizzle
// nearest-neighbor scaler with letterbox fit and red/blue swap over a frame store
// ----------------------------------------------------------------------------
// pipeline: classify, dividend, 3 divider stages, frame read; one transaction
//   per cycle, set by the pipelined divider, while m_ready and the fit unit allow
// after reset or any register write the fit unit runs with s_ready low
// reset: synchronous active-low aresetn clears control state and loads the
//   register defaults; the frame store is not cleared
module nearest_scaler_letterbox_swizzle (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic [nsls_pkg::CX_W-1:0]          s_coord_x,
    input  logic [nsls_pkg::CX_W-1:0]          s_coord_y,
    input  logic [nsls_pkg::PIX_W-1:0]         s_pixel_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [nsls_pkg::PIX_W-1:0]         m_pixel_out,
    output logic                               m_config_error,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nsls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nsls_pkg::CFG_DAT_W-1:0]     cfg_data
);

    typedef enum logic [1:0] {SU_MUL, SU_LOAD, SU_DIV, SU_FIN} su_state_t;

    // configuration registers
    logic [nsls_pkg::SW_W-1:0] src_width_reg, src_height_reg;
    logic [nsls_pkg::DW_W-1:0] dst_width_reg, dst_height_reg;
    logic                      swap_rb_reg, keep_asp_reg;

    // fit unit state
    su_state_t                   su_state_reg;
    logic                        busy_reg;
    logic [nsls_pkg::PROD_W-1:0] prod_a_reg, prod_b_reg, su_rem_reg;
    logic [nsls_pkg::SW_W-1:0]   su_den_reg;
    logic [nsls_pkg::DW_W-1:0]   su_q_reg;
    logic [nsls_pkg::SUC_W-1:0]  su_cnt_reg;
    logic                        shrink_h_reg;
    logic [nsls_pkg::DW_W-1:0]   fit_w_reg, fit_h_reg, right_reg, bottom_reg;
    logic [nsls_pkg::CX_W-1:0]   left_reg, top_reg;

    // pipeline
    nsls_pkg::stage_t st1_reg, st2_reg, st3_reg, st4_reg, st5_reg;
    nsls_pkg::stage_t st1_next, st2_next, st3_next, st4_next, st5_next;
    logic                        adv;
    logic                        out_valid_reg, out_err_reg, out_border_reg;
    logic [nsls_pkg::PIX_W-1:0]  rdata_reg;
    logic [nsls_pkg::PIX_W-1:0]  frame_mem [nsls_pkg::FRAME_DEPTH];

    logic [nsls_pkg::SW_W-1:0]   sw, sh;
    logic [nsls_pkg::DW_W-1:0]   dw, dh;
    logic                        dim_zero;
    logic [nsls_pkg::Q_W-1:0]    sx, sy;
    logic [nsls_pkg::ADDR_W-1:0] wr_addr, rd_addr;
    logic [nsls_pkg::PROD_W-1:0] su_trial;
    logic [nsls_pkg::DW_W-1:0]   su_fit;
    logic [nsls_pkg::DW_W-1:0]   fw_fin, fh_fin;

    // capped dimensions
    assign sw = (src_width_reg > nsls_pkg::SW_W'(nsls_pkg::MAX_SRC_WIDTH))
              ? nsls_pkg::SW_W'(nsls_pkg::MAX_SRC_WIDTH) : src_width_reg;
    assign sh = (src_height_reg > nsls_pkg::SW_W'(nsls_pkg::MAX_SRC_HEIGHT))
              ? nsls_pkg::SW_W'(nsls_pkg::MAX_SRC_HEIGHT) : src_height_reg;
    assign dw = (dst_width_reg > nsls_pkg::DW_W'(nsls_pkg::MAX_DST_DIM))
              ? nsls_pkg::DW_W'(nsls_pkg::MAX_DST_DIM) : dst_width_reg;
    assign dh = (dst_height_reg > nsls_pkg::DW_W'(nsls_pkg::MAX_DST_DIM))
              ? nsls_pkg::DW_W'(nsls_pkg::MAX_DST_DIM) : dst_height_reg;
    assign dim_zero = (sw == '0) || (sh == '0) || (dw == '0) || (dh == '0);

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= nsls_pkg::SW_W'(256);
            src_height_reg <= nsls_pkg::SW_W'(256);
            dst_width_reg  <= nsls_pkg::DW_W'(1024);
            dst_height_reg <= nsls_pkg::DW_W'(1024);
            swap_rb_reg    <= 1'b0;
            keep_asp_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (nsls_pkg::cfg_reg_t'(cfg_index))
                nsls_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[nsls_pkg::SW_W-1:0];
                nsls_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data[nsls_pkg::SW_W-1:0];
                nsls_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                nsls_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                nsls_pkg::REG_SWAP_RB:    swap_rb_reg    <= cfg_data[0];
                nsls_pkg::REG_KEEP_ASP:   keep_asp_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // fit unit combinational helpers
    assign su_trial = nsls_pkg::PROD_W'(su_den_reg) << su_cnt_reg;
    assign su_fit   = (su_q_reg == '0) ? nsls_pkg::DW_W'(1) : su_q_reg;
    always_comb begin
        fw_fin = dw;
        fh_fin = dh;
        if (keep_asp_reg && !dim_zero) begin
            if (shrink_h_reg) begin
                fh_fin = su_fit;
            end else begin
                fw_fin = su_fit;
            end
        end
    end

    // fit unit: aspect compare, serial divide, centering
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            su_state_reg <= SU_MUL;
            busy_reg     <= 1'b1;
        end else if (cfg_valid) begin
            su_state_reg <= SU_MUL;
            busy_reg     <= 1'b1;
        end else begin
            unique case (su_state_reg)
                SU_MUL: begin
                    if (busy_reg) begin
                        prod_a_reg   <= nsls_pkg::PROD_W'(sw) * nsls_pkg::PROD_W'(dh);
                        prod_b_reg   <= nsls_pkg::PROD_W'(sh) * nsls_pkg::PROD_W'(dw);
                        su_state_reg <= SU_LOAD;
                    end
                end
                SU_LOAD: begin
                    shrink_h_reg <= prod_a_reg > prod_b_reg;
                    su_rem_reg   <= (prod_a_reg > prod_b_reg) ? prod_b_reg : prod_a_reg;
                    su_den_reg   <= (prod_a_reg > prod_b_reg) ? sw : sh;
                    su_q_reg     <= '0;
                    su_cnt_reg   <= nsls_pkg::SUC_W'(nsls_pkg::DW_W - 1);
                    su_state_reg <= SU_DIV;
                end
                SU_DIV: begin
                    if (su_rem_reg >= su_trial) begin
                        su_rem_reg           <= su_rem_reg - su_trial;
                        su_q_reg[su_cnt_reg] <= 1'b1;
                    end
                    if (su_cnt_reg == '0) begin
                        su_state_reg <= SU_FIN;
                    end else begin
                        su_cnt_reg <= su_cnt_reg - 1'b1;
                    end
                end
                SU_FIN: begin
                    fit_w_reg    <= fw_fin;
                    fit_h_reg    <= fh_fin;
                    left_reg     <= nsls_pkg::CX_W'((dw - fw_fin) >> 1);
                    top_reg      <= nsls_pkg::CX_W'((dh - fh_fin) >> 1);
                    right_reg    <= ((dw - fw_fin) >> 1) + fw_fin;
                    bottom_reg   <= ((dh - fh_fin) >> 1) + fh_fin;
                    busy_reg     <= 1'b0;
                    su_state_reg <= SU_MUL;
                end
                default: su_state_reg <= SU_MUL;
            endcase
        end
    end

    // pipeline advance and input handshake
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv && !busy_reg;

    // restoring divide steps for one stage
    function automatic void div3(input logic [nsls_pkg::NUM_W-1:0] rem_i,
                                 input logic [nsls_pkg::Q_W-1:0] q_i,
                                 input logic [nsls_pkg::DW_W-1:0] den,
                                 input int top_bit,
                                 output logic [nsls_pkg::NUM_W-1:0] rem_o,
                                 output logic [nsls_pkg::Q_W-1:0] q_o);
        logic [nsls_pkg::NUM_W-1:0] trial;
        rem_o = rem_i;
        q_o   = q_i;
        for (int i = 0; i < 3; i++) begin
            trial = nsls_pkg::NUM_W'(den) << (top_bit - i);
            if (rem_o >= trial) begin
                rem_o = rem_o - trial;
                q_o[top_bit - i] = 1'b1;
            end
        end
    endfunction

    // stage 1: classify, offset into fitted area
    always_comb begin
        st1_next        = '0;
        st1_next.valid  = s_valid && !busy_reg;
        st1_next.rd     = (s_command == nsls_pkg::CMD_READ);
        st1_next.wr_ok  = (s_command == nsls_pkg::CMD_WRITE)
                       && ({1'b0, s_coord_x} < (nsls_pkg::CX_W+1)'(sw))
                       && ({1'b0, s_coord_y} < (nsls_pkg::CX_W+1)'(sh));
        st1_next.err    = dim_zero;
        st1_next.border = (s_coord_x < left_reg) || ({1'b0, s_coord_x} >= right_reg)
                       || (s_coord_y < top_reg) || ({1'b0, s_coord_y} >= bottom_reg);
        st1_next.pix    = s_pixel_in;
        if (s_command == nsls_pkg::CMD_READ) begin
            st1_next.ax = s_coord_x - left_reg;
            st1_next.ay = s_coord_y - top_reg;
        end else begin
            st1_next.ax = s_coord_x;
            st1_next.ay = s_coord_y;
        end
    end

    // stage 2: dividend products
    always_comb begin
        st2_next       = st1_reg;
        st2_next.rem_x = nsls_pkg::NUM_W'(st1_reg.ax) * nsls_pkg::NUM_W'(sw);
        st2_next.rem_y = nsls_pkg::NUM_W'(st1_reg.ay) * nsls_pkg::NUM_W'(sh);
        st2_next.q_x   = '0;
        st2_next.q_y   = '0;
    end

    // stages 3 to 5: three quotient bits each
    always_comb begin
        st3_next = st2_reg;
        div3(st2_reg.rem_x, st2_reg.q_x, fit_w_reg, 8, st3_next.rem_x, st3_next.q_x);
        div3(st2_reg.rem_y, st2_reg.q_y, fit_h_reg, 8, st3_next.rem_y, st3_next.q_y);
        st4_next = st3_reg;
        div3(st3_reg.rem_x, st3_reg.q_x, fit_w_reg, 5, st4_next.rem_x, st4_next.q_x);
        div3(st3_reg.rem_y, st3_reg.q_y, fit_h_reg, 5, st4_next.rem_y, st4_next.q_y);
        st5_next = st4_reg;
        div3(st4_reg.rem_x, st4_reg.q_x, fit_w_reg, 2, st5_next.rem_x, st5_next.q_x);
        div3(st4_reg.rem_y, st4_reg.q_y, fit_h_reg, 2, st5_next.rem_y, st5_next.q_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg.valid <= 1'b0;
            st2_reg.valid <= 1'b0;
            st3_reg.valid <= 1'b0;
            st4_reg.valid <= 1'b0;
            st5_reg.valid <= 1'b0;
        end else if (adv) begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
            st5_reg <= st5_next;
        end
    end

    // clamp and frame addresses
    assign sx = (st5_reg.q_x > sw - 1'b1) ? sw - 1'b1 : st5_reg.q_x;
    assign sy = (st5_reg.q_y > sh - 1'b1) ? sh - 1'b1 : st5_reg.q_y;
    assign wr_addr = {st5_reg.ay[nsls_pkg::YA_W-1:0], st5_reg.ax[nsls_pkg::XA_W-1:0]};
    assign rd_addr = {sy[nsls_pkg::YA_W-1:0], sx[nsls_pkg::XA_W-1:0]};

    // frame store
    always_ff @(posedge aclk) begin
        if (adv && st5_reg.valid && st5_reg.wr_ok) begin
            frame_mem[wr_addr] <= st5_reg.pix;
        end
        if (adv && st5_reg.valid && st5_reg.rd) begin
            rdata_reg <= frame_mem[rd_addr];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg  <= st5_reg.valid && st5_reg.rd;
            out_err_reg    <= st5_reg.err;
            out_border_reg <= st5_reg.border;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_config_error = out_err_reg;
    always_comb begin
        if (out_err_reg) begin
            m_pixel_out = '0;
        end else if (out_border_reg) begin
            m_pixel_out = nsls_pkg::BORDER_PIXEL;
        end else if (swap_rb_reg) begin
            m_pixel_out = {rdata_reg[31:24], rdata_reg[7:0], rdata_reg[15:8],
                           rdata_reg[23:16]};
        end else begin
            m_pixel_out = rdata_reg;
        end
    end

    // checks
    `include "nearest_scaler_letterbox_swizzle_macros.svh"
    `NSLS_ASSERT_IMP(a_busy_blocks, busy_reg, !s_ready, "input taken during fit setup")
    `NSLS_ASSERT_NXT(a_cfg_restarts, cfg_valid, busy_reg, "register write did not restart fit")
    `NSLS_ASSERT_IMP(a_err_zero, m_valid && m_config_error, m_pixel_out == '0,
        "error pixel not zero")
    `NSLS_ASSERT_IMP(a_border_px, m_valid && !m_config_error && out_border_reg,
        m_pixel_out == nsls_pkg::BORDER_PIXEL, "border pixel wrong")

endmodule

[verif/scaler_checker.sv]
// ----------------------------------------------------------------------------
// scaler_checker
// watches the config, input and result channels of the letterbox scaler,
// predicts every read result from its own frame copy and compares in order
// ----------------------------------------------------------------------------
module scaler_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_command,
    input  logic [nsls_pkg::CX_W-1:0]      s_coord_x,
    input  logic [nsls_pkg::CX_W-1:0]      s_coord_y,
    input  logic [nsls_pkg::PIX_W-1:0]     s_pixel_in,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [nsls_pkg::PIX_W-1:0]     m_pixel_out,
    input  logic                           m_config_error,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [nsls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nsls_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                             mismatch_count,
    output int                             pending_count
);
    import nsls_pkg::*;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             err;
    } scaled_px_t;

    logic [PIX_W-1:0] frame_copy [FRAME_DEPTH];
    logic [SW_W-1:0]  src_w_reg, src_h_reg;
    logic [DW_W-1:0]  dst_w_reg, dst_h_reg;
    logic             swap_reg, aspect_reg;
    scaled_px_t       expected_px [$];

    initial mismatch_count = 0;
    assign pending_count = expected_px.size();

    // map one destination pixel to its expected output
    function automatic scaled_px_t scale_pixel(logic [CX_W-1:0] x, logic [CX_W-1:0] y);
        longint unsigned sw, sh, dw, dh, fw, fh, left, top, sx, sy;
        logic [PIX_W-1:0] p;
        scaled_px_t r;
        sw = (src_w_reg > MAX_SRC_WIDTH)  ? MAX_SRC_WIDTH  : src_w_reg;
        sh = (src_h_reg > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : src_h_reg;
        dw = (dst_w_reg > MAX_DST_DIM)    ? MAX_DST_DIM    : dst_w_reg;
        dh = (dst_h_reg > MAX_DST_DIM)    ? MAX_DST_DIM    : dst_h_reg;
        r.err = 1'b0;
        if (sw == 0 || sh == 0 || dw == 0 || dh == 0) begin
            r.pix = '0;
            r.err = 1'b1;
            return r;
        end
        fw = dw;
        fh = dh;
        // shrink one axis to keep the source aspect
        if (aspect_reg) begin
            if (sw * fh > sh * fw) begin
                fh = fw * sh / sw;
                if (fh == 0) fh = 1;
            end else begin
                fw = fh * sw / sh;
                if (fw == 0) fw = 1;
            end
        end
        left = (dw - fw) / 2;
        top  = (dh - fh) / 2;
        if (x < left || x - left >= fw || y < top || y - top >= fh) begin
            r.pix = BORDER_PIXEL;
            return r;
        end
        sx = (x - left) * sw / fw;
        sy = (y - top) * sh / fh;
        if (sx > sw - 1) sx = sw - 1;
        if (sy > sh - 1) sy = sh - 1;
        p = frame_copy[sy * MAX_SRC_WIDTH + sx];
        if (swap_reg) p = {p[31:24], p[7:0], p[15:8], p[23:16]};
        r.pix = p;
        return r;
    endfunction

    // config writes, input transactions and result compare
    always @(posedge aclk) begin
        scaled_px_t exp_px;
        if (!aresetn) begin
            src_w_reg  <= 9'd256;
            src_h_reg  <= 9'd256;
            dst_w_reg  <= 13'd1024;
            dst_h_reg  <= 13'd1024;
            swap_reg   <= 1'b0;
            aspect_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SRC_WIDTH:  src_w_reg  <= cfg_data[SW_W-1:0];
                    REG_SRC_HEIGHT: src_h_reg  <= cfg_data[SW_W-1:0];
                    REG_DST_WIDTH:  dst_w_reg  <= cfg_data;
                    REG_DST_HEIGHT: dst_h_reg  <= cfg_data;
                    REG_SWAP_RB:    swap_reg   <= cfg_data[0];
                    REG_KEEP_ASP:   aspect_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_command == CMD_WRITE) begin
                    if (s_coord_x < ((src_w_reg > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : src_w_reg) &&
                        s_coord_y < ((src_h_reg > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : src_h_reg))
                        frame_copy[s_coord_y * MAX_SRC_WIDTH + s_coord_x] = s_pixel_in;
                end else begin
                    expected_px.push_back(scale_pixel(s_coord_x, s_coord_y));
                end
            end
            if (m_valid && m_ready) begin
                if (expected_px.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result: pixel %h err %b", m_pixel_out,
                                 m_config_error);
                    mismatch_count++;
                end else begin
                    exp_px = expected_px.pop_front();
                    if (exp_px.pix !== m_pixel_out || exp_px.err !== m_config_error) begin
                        if (mismatch_count < 10)
                            $display("mismatch: expected pixel %h err %b, got pixel %h err %b",
                                     exp_px.pix, exp_px.err, m_pixel_out, m_config_error);
                        mismatch_count++;
                    end
                end
            end
        end
    end
endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the letterbox scaler: per phase it programs all registers,
// fills the whole source area, then streams reads and writes, partly under
// random idling on both channels; the checker module judges every result
// ----------------------------------------------------------------------------
module tb_top;
    import nsls_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int LONG_HOLD      = 300;
    localparam int TOTAL_ITEMS    = 1300;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_command = CMD_WRITE;
    logic [CX_W-1:0]      s_coord_x = '0;
    logic [CX_W-1:0]      s_coord_y = '0;
    logic [PIX_W-1:0]     s_pixel_in = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PIX_W-1:0]     m_pixel_out;
    logic                 m_config_error;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    int                   mismatch_count, pending_count;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_go = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int sent_count = 0;

    always #5 aclk = ~aclk;

    nearest_scaler_letterbox_swizzle dut (.*);

    scaler_checker u_checker (.*);

    // receiver readiness with one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_taken) begin
            m_ready    <= 1'b0;
            hold_left  <= LONG_HOLD;
            hold_taken <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(logic cmd, int x, int y, logic [PIX_W-1:0] pix);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_coord_x  <= CX_W'(x);
        s_coord_y  <= CX_W'(y);
        s_pixel_in <= pix;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    task automatic write_reg(cfg_reg_t idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DAT_W'(val);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // wait for every result, then let writes in flight retire
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // program all registers and fill the whole active source area
    task automatic start_phase(int sw, int sh, int dw, int dh, bit swp, bit asp);
        int cw, ch;
        drain();
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_SWAP_RB, swp);
        write_reg(REG_KEEP_ASP, asp);
        cfg_valid <= 1'b0;
        cw = (sw > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : sw;
        ch = (sh > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : sh;
        for (int yy = 0; yy < ch; yy++)
            for (int xx = 0; xx < cw; xx++)
                send_item(CMD_WRITE, xx, yy, (yy == 0 && xx == 0) ? 32'h0 :
                          (yy == 0 && xx == 1) ? 32'hFFFF_FFFF : $urandom);
    endtask

    initial begin
        int item_count, base_count, span, sw, sh, dw, dh, dwc, dhc, n, pick, rx, ry;
        bit hold_done;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: letterboxed, swapped, small source
        start_phase(4, 3, 13, 7, 1'b1, 1'b1);
        send_item(CMD_READ, 0, 0, 32'h0);
        send_item(CMD_READ, 12, 6, 32'hFFFF_FFFF);
        send_item(CMD_READ, 6, 3, 32'h0);
        send_item(CMD_READ, 1, 3, 32'h0);
        send_item(CMD_READ, 11, 3, 32'h0);
        send_item(CMD_READ, 4095, 4095, 32'h0);
        send_item(CMD_READ, 13, 0, 32'h0);
        send_item(CMD_WRITE, 4095, 4095, 32'h1234_5678);
        send_item(CMD_WRITE, 4, 0, 32'hDEAD_BEEF);
        send_item(CMD_READ, 2, 0, 32'h0);
        send_item(CMD_READ, 2, 6, 32'h0);
        // directed: zero dimension gives config error
        start_phase(4, 3, 0, 7, 1'b0, 1'b0);
        send_item(CMD_WRITE, 0, 0, 32'hAAAA_5555);
        send_item(CMD_READ, 0, 0, 32'h0);
        // directed: oversized width, one row, oversized destination
        start_phase(511, 1, 8191, 8191, 1'b0, 1'b1);
        send_item(CMD_READ, 0, 2048, 32'h0);
        send_item(CMD_READ, 4095, 2048, 32'h0);
        send_item(CMD_READ, 2047, 2047, 32'h0);
        send_item(CMD_READ, 0, 0, 32'h0);

        // random phases, counted over every input transaction
        base_count = sent_count;
        span       = TOTAL_ITEMS - base_count;
        hold_done  = 1'b0;
        while (sent_count < TOTAL_ITEMS) begin
            item_count = sent_count - base_count;
            if (item_count < span / 3) begin
                tx_idle_pct = 33; rx_idle_pct = 61;
            end else if (item_count < (2 * span) / 3) begin
                tx_idle_pct = 61; rx_idle_pct = 33;
            end else begin
                tx_idle_pct = 0;  rx_idle_pct = 0;
            end
            pick = $urandom_range(19);
            sw = (pick == 0) ? 0 : (pick == 1) ? 256 : $urandom_range(1, 12);
            sh = (pick == 2) ? 0 : (pick == 3) ? 511 : $urandom_range(1, 12);
            if (sw * sh > 512) sw = 1;
            pick = $urandom_range(19);
            dw = (pick == 0) ? 0 : (pick == 1) ? 4096 : (pick == 2) ? 8191 :
                 $urandom_range(1, 64);
            dh = (pick == 3) ? 0 : (pick == 4) ? 4095 : $urandom_range(1, 64);
            start_phase(sw, sh, dw, dh, $urandom_range(1), $urandom_range(1));
            dwc = (dw > MAX_DST_DIM) ? MAX_DST_DIM : dw;
            dhc = (dh > MAX_DST_DIM) ? MAX_DST_DIM : dh;
            if (!hold_done && (sent_count - base_count) > span / 5) begin
                hold_go   = 1'b1;
                hold_done = 1'b1;
            end
            n = $urandom_range(40, 80);
            for (int k = 0; k < n; k++) begin
                pick = $urandom_range(9);
                if (pick < 7) begin
                    rx = (dwc + 3 > 4095) ? $urandom_range(4095) : $urandom_range(0, dwc + 3);
                    ry = (dhc + 3 > 4095) ? $urandom_range(4095) : $urandom_range(0, dhc + 3);
                    send_item(CMD_READ, rx, ry, $urandom);
                end else if (pick == 7) begin
                    send_item(CMD_READ, $urandom_range(4095), $urandom_range(4095), $urandom);
                end else if (pick == 8) begin
                    send_item(CMD_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                              $urandom);
                end else begin
                    send_item(CMD_WRITE, $urandom_range(4095), $urandom_range(4095),
                              $urandom);
                end
            end
        end

        drain();
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
